@@ design/dtts_pkg.sv @@
// Package for the duration text parser: phase and unit types, widths and scale constants.
`default_nettype none

package dtts_pkg;

  // Field and state widths.
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned TOTAL_W    = 63;
  localparam int unsigned FRAC_W     = 10;
  localparam int unsigned NUM_CNT_W  = 4;
  localparam int unsigned FRAC_CNT_W = 2;
  localparam int unsigned DIGIT_W    = 4;

  // A number of up to twelve digits times one year of seconds fits in 65 bits.
  localparam int unsigned SCALED_W   = 65;
  localparam int unsigned SUM_W      = SCALED_W + 1;

  localparam int unsigned NUM_UNITS  = 7;
  localparam int unsigned UNIT_W     = 3;

  // Defaults for the digit limits of the top level.
  localparam int unsigned DEF_MAX_NUMBER_DIGITS   = 12;
  localparam int unsigned DEF_MAX_FRACTION_DIGITS = 3;

  // Stream payload widths, padded to whole bytes.
  localparam int unsigned S_TDATA_W = 8;
  localparam int unsigned M_TDATA_W = 80;

  // Parse phases.
  typedef enum logic [3:0] {
    PH_WANT_P     = 4'd0,
    PH_AFTER_P    = 4'd1,
    PH_NUM_START  = 4'd2,
    PH_NUM        = 4'd3,
    PH_NUM_WS     = 4'd4,
    PH_FRAC_START = 4'd5,
    PH_FRAC       = 4'd6,
    PH_FRAC_WS    = 4'd7,
    PH_ACCEPT     = 4'd8,
    PH_REJECT     = 4'd9
  } phase_e;

  // Units, each with its own scaled copy of the number being read.
  typedef enum logic [UNIT_W-1:0] {
    U_SEC   = 3'd0,
    U_MIN   = 3'd1,
    U_HOUR  = 3'd2,
    U_DAY   = 3'd3,
    U_WEEK  = 3'd4,
    U_MONTH = 3'd5,
    U_YEAR  = 3'd6
  } unit_e;

  typedef logic [SCALED_W-1:0] scaled_t;

  // Seconds per unit.
  function automatic scaled_t unit_scale(unit_e u);
    scaled_t k;
    case (u)
      U_SEC:   k = scaled_t'(1);
      U_MIN:   k = scaled_t'(60);
      U_HOUR:  k = scaled_t'(3600);
      U_DAY:   k = scaled_t'(86400);
      U_WEEK:  k = scaled_t'(604800);
      U_MONTH: k = scaled_t'(2592000);
      U_YEAR:  k = scaled_t'(31536000);
      default: k = scaled_t'(0);
    endcase
    return k;
  endfunction

  // One decimal digit times the seconds of a unit.
  function automatic scaled_t digit_scaled(unit_e u, logic [DIGIT_W-1:0] d);
    scaled_t p;
    p = unit_scale(u) * scaled_t'(d);
    return p;
  endfunction

endpackage

`default_nettype wire

@@ design/duration_text_to_seconds.sv @@
// Top level of the streaming duration text parser that sums a duration into seconds.
`default_nettype none

//  Channel   Dir  Fields (tdata low bit up)                    Marks
//  s_axis    in   char_code[7:0]                               tlast = last character
//  m_axis    out  seconds[62:0], fraction_value[72:63], pad    tuser = accepted
//
// Each character passes through the input register and then the parse logic; the outcome
// of a last character is loaded into the result register.
// One character is taken per cycle unless a last character waits on an untaken result; the rate
// is set by the parse stage, whose unit add and per-unit scaled digit updates are combinational.
// Reset puts the parser at the start of a string with no item held.
// A result that is not taken stalls only a character marked last; others still flow.

module duration_text_to_seconds #(
  parameter int unsigned MAX_NUMBER_DIGITS   = dtts_pkg::DEF_MAX_NUMBER_DIGITS,
  parameter int unsigned MAX_FRACTION_DIGITS = dtts_pkg::DEF_MAX_FRACTION_DIGITS
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [dtts_pkg::S_TDATA_W-1:0]  s_axis_tdata,   // char_code[7:0]
  input  wire logic                            s_axis_tlast,   // last
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [dtts_pkg::M_TDATA_W-1:0]       m_axis_tdata,   // seconds[62:0],
                                                               // fraction_value[72:63]
  output logic                                 m_axis_tuser    // accepted
);

  // Character codes.
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CASE  = 8'h20;
  localparam logic [7:0] CH_LC_Y  = 8'h79;
  localparam logic [7:0] CH_LC_W  = 8'h77;
  localparam logic [7:0] CH_LC_D  = 8'h64;
  localparam logic [7:0] CH_LC_H  = 8'h68;
  localparam logic [7:0] CH_LC_M  = 8'h6D;
  localparam logic [7:0] CH_LC_S  = 8'h73;
  localparam logic [7:0] CH_LC_T  = 8'h74;

  localparam logic [dtts_pkg::NUM_CNT_W-1:0] NUM_MAX =
    dtts_pkg::NUM_CNT_W'(MAX_NUMBER_DIGITS);
  localparam logic [dtts_pkg::FRAC_CNT_W-1:0] FRAC_MAX =
    dtts_pkg::FRAC_CNT_W'(MAX_FRACTION_DIGITS);

  // Input register.
  logic [dtts_pkg::CHAR_W-1:0] char_q;
  logic                        last_q;
  logic                        in_valid_q;

  // Parser state.
  dtts_pkg::phase_e                 phase_q, phase_d;
  dtts_pkg::scaled_t                scaled_q [dtts_pkg::NUM_UNITS];
  dtts_pkg::scaled_t                scaled_d [dtts_pkg::NUM_UNITS];
  logic [dtts_pkg::NUM_CNT_W-1:0]   num_cnt_q, num_cnt_d;
  logic [dtts_pkg::FRAC_W-1:0]      frac_acc_q, frac_acc_d;
  logic [dtts_pkg::FRAC_CNT_W-1:0]  frac_cnt_q, frac_cnt_d;
  logic [dtts_pkg::TOTAL_W-1:0]     total_q, total_d;
  logic                             time_q, time_d;
  logic                             week_q, week_d;
  logic                             year_q, year_d;
  logic                             any_q, any_d;

  // Result register.
  logic                             out_valid_q;
  logic                             accepted_q;
  logic [dtts_pkg::TOTAL_W-1:0]     seconds_q;
  logic [dtts_pkg::FRAC_W-1:0]      frac_out_q;

  logic process;
  logic emit;

  // Character classes.
  logic [7:0]                   ch_lc;
  logic                         is_digit;
  logic                         is_space;
  logic [dtts_pkg::DIGIT_W-1:0] digit;

  // Unit add.
  dtts_pkg::unit_e              add_unit;
  logic [dtts_pkg::SUM_W-1:0]   sum;
  logic                         add_ovf;
  logic [13:0]                  frac_mul;
  logic                         ok;

  // The parse stage moves when it holds a character and its result has room.
  assign process       = in_valid_q && (!last_q || !out_valid_q || m_axis_tready);
  assign emit          = process && last_q;
  assign s_axis_tready = !in_valid_q || process;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (process) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      char_q <= s_axis_tdata[dtts_pkg::CHAR_W-1:0];
      last_q <= s_axis_tlast;
    end
  end

  // Character classification.
  always_comb begin
    ch_lc    = char_q | CH_CASE;
    is_digit = (char_q inside {[8'h30:8'h39]});
    is_space = (char_q == CH_SPACE) || (char_q inside {[8'h09:8'h0D]});
    digit    = char_q[dtts_pkg::DIGIT_W-1:0];
  end

  // Unit picked by the current letter; a fractional group always adds seconds.
  always_comb begin
    case (ch_lc)
      CH_LC_Y: add_unit = dtts_pkg::U_YEAR;
      CH_LC_W: add_unit = dtts_pkg::U_WEEK;
      CH_LC_D: add_unit = dtts_pkg::U_DAY;
      CH_LC_H: add_unit = dtts_pkg::U_HOUR;
      CH_LC_M: add_unit = year_q ? dtts_pkg::U_MONTH : dtts_pkg::U_MIN;
      default: add_unit = dtts_pkg::U_SEC;
    endcase
    if (phase_q == dtts_pkg::PH_FRAC || phase_q == dtts_pkg::PH_FRAC_WS) begin
      add_unit = dtts_pkg::U_SEC;
    end
    sum      = dtts_pkg::SUM_W'(total_q) + dtts_pkg::SUM_W'(scaled_q[add_unit]);
    add_ovf  = |sum[dtts_pkg::SUM_W-1:dtts_pkg::TOTAL_W];
    frac_mul = (14'(frac_acc_q) << 3) + (14'(frac_acc_q) << 1) + 14'(digit);
  end

  // Next parser state.
  always_comb begin
    phase_d    = phase_q;
    num_cnt_d  = num_cnt_q;
    frac_acc_d = frac_acc_q;
    frac_cnt_d = frac_cnt_q;
    total_d    = total_q;
    time_d     = time_q;
    week_d     = week_q;
    year_d     = year_q;
    any_d      = any_q;
    ok         = 1'b1;
    for (int unsigned i = 0; i < dtts_pkg::NUM_UNITS; i++) begin
      scaled_d[i] = scaled_q[i];
    end

    case (phase_q)
      dtts_pkg::PH_WANT_P: begin
        phase_d = (char_q == CH_P) ? dtts_pkg::PH_AFTER_P : dtts_pkg::PH_REJECT;
      end
      dtts_pkg::PH_AFTER_P, dtts_pkg::PH_NUM_START: begin
        if (phase_q == dtts_pkg::PH_AFTER_P && ch_lc == CH_LC_T) begin
          time_d  = 1'b1;
          phase_d = dtts_pkg::PH_NUM_START;
        end else if (!is_digit) begin
          phase_d = any_q ? dtts_pkg::PH_ACCEPT : dtts_pkg::PH_REJECT;
        end else begin
          // First digit of a number: load every scaled copy.
          for (int unsigned i = 0; i < dtts_pkg::NUM_UNITS; i++) begin
            scaled_d[i] = dtts_pkg::digit_scaled(dtts_pkg::unit_e'(i[2:0]), digit);
          end
          num_cnt_d = dtts_pkg::NUM_CNT_W'(1);
          phase_d   = dtts_pkg::PH_NUM;
        end
      end
      dtts_pkg::PH_NUM, dtts_pkg::PH_NUM_WS: begin
        if (phase_q == dtts_pkg::PH_NUM && is_digit) begin
          if (num_cnt_q >= NUM_MAX) begin
            phase_d = dtts_pkg::PH_REJECT;
          end else begin
            // Times ten plus the digit, in every unit at once.
            for (int unsigned i = 0; i < dtts_pkg::NUM_UNITS; i++) begin
              scaled_d[i] = (scaled_q[i] << 3) + (scaled_q[i] << 1) +
                            dtts_pkg::digit_scaled(dtts_pkg::unit_e'(i[2:0]), digit);
            end
            num_cnt_d = num_cnt_q + 1'b1;
          end
        end else if (is_space) begin
          phase_d = dtts_pkg::PH_NUM_WS;
        end else if (char_q == CH_DOT) begin
          if (week_q) begin
            phase_d = dtts_pkg::PH_REJECT;
          end else begin
            frac_acc_d = '0;
            frac_cnt_d = '0;
            phase_d    = dtts_pkg::PH_FRAC_START;
          end
        end else begin
          // Unit letter.
          ok = 1'b1;
          case (ch_lc)
            CH_LC_Y: begin
              ok     = !time_q;
              year_d = 1'b1;
            end
            CH_LC_W: begin
              ok     = !time_q;
              week_d = 1'b1;
              year_d = 1'b0;
            end
            CH_LC_D: begin
              ok     = !time_q;
              year_d = 1'b0;
            end
            CH_LC_H, CH_LC_S: begin
              year_d = 1'b0;
            end
            CH_LC_M: begin
              ok = 1'b1;
            end
            CH_LC_T: begin
              ok     = !week_q;
              year_d = 1'b0;
              time_d = 1'b1;
            end
            default: begin
              ok = 1'b0;
            end
          endcase
          if (ch_lc != CH_LC_T && add_ovf) begin
            ok = 1'b0;
          end
          if (!ok) begin
            phase_d = dtts_pkg::PH_REJECT;
          end else begin
            if (ch_lc != CH_LC_T) begin
              total_d = sum[dtts_pkg::TOTAL_W-1:0];
            end
            any_d   = 1'b1;
            phase_d = dtts_pkg::PH_NUM_START;
          end
        end
      end
      dtts_pkg::PH_FRAC_START: begin
        if (!is_digit) begin
          phase_d = dtts_pkg::PH_REJECT;
        end else begin
          frac_acc_d = dtts_pkg::FRAC_W'(digit);
          frac_cnt_d = dtts_pkg::FRAC_CNT_W'(1);
          phase_d    = dtts_pkg::PH_FRAC;
        end
      end
      dtts_pkg::PH_FRAC, dtts_pkg::PH_FRAC_WS: begin
        if (phase_q == dtts_pkg::PH_FRAC && is_digit) begin
          if (frac_cnt_q >= FRAC_MAX) begin
            phase_d = dtts_pkg::PH_REJECT;
          end else begin
            frac_acc_d = frac_mul[dtts_pkg::FRAC_W-1:0];
            frac_cnt_d = frac_cnt_q + 1'b1;
          end
        end else if (is_space) begin
          phase_d = dtts_pkg::PH_FRAC_WS;
        end else if (ch_lc == CH_LC_S) begin
          // Fractional seconds add the whole number once.
          if (add_ovf) begin
            phase_d = dtts_pkg::PH_REJECT;
          end else begin
            total_d = sum[dtts_pkg::TOTAL_W-1:0];
            any_d   = 1'b1;
            phase_d = dtts_pkg::PH_NUM_START;
          end
        end else begin
          phase_d = dtts_pkg::PH_REJECT;
        end
      end
      dtts_pkg::PH_ACCEPT: begin
        phase_d = dtts_pkg::PH_ACCEPT;
      end
      default: begin
        phase_d = dtts_pkg::PH_REJECT;
      end
    endcase
  end

  // Parser state registers; the last character of a string starts the next one fresh.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= dtts_pkg::PH_WANT_P;
      num_cnt_q  <= '0;
      frac_acc_q <= '0;
      frac_cnt_q <= '0;
      total_q    <= '0;
      time_q     <= 1'b0;
      week_q     <= 1'b0;
      year_q     <= 1'b0;
      any_q      <= 1'b0;
    end else if (emit) begin
      phase_q    <= dtts_pkg::PH_WANT_P;
      num_cnt_q  <= '0;
      frac_acc_q <= '0;
      frac_cnt_q <= '0;
      total_q    <= '0;
      time_q     <= 1'b0;
      week_q     <= 1'b0;
      year_q     <= 1'b0;
      any_q      <= 1'b0;
    end else if (process) begin
      phase_q    <= phase_d;
      num_cnt_q  <= num_cnt_d;
      frac_acc_q <= frac_acc_d;
      frac_cnt_q <= frac_cnt_d;
      total_q    <= total_d;
      time_q     <= time_d;
      week_q     <= week_d;
      year_q     <= year_d;
      any_q      <= any_d;
    end
  end

  // Scaled copies of the number are payload and need no reset.
  always_ff @(posedge clk_i) begin
    if (process) begin
      for (int unsigned i = 0; i < dtts_pkg::NUM_UNITS; i++) begin
        scaled_q[i] <= scaled_d[i];
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      if (phase_d == dtts_pkg::PH_ACCEPT ||
          ((phase_d == dtts_pkg::PH_AFTER_P || phase_d == dtts_pkg::PH_NUM_START ||
            phase_d == dtts_pkg::PH_NUM || phase_d == dtts_pkg::PH_NUM_WS) && any_d)) begin
        accepted_q <= 1'b1;
        seconds_q  <= total_d;
        frac_out_q <= frac_acc_d;
      end else begin
        accepted_q <= 1'b0;
        seconds_q  <= '0;
        frac_out_q <= '0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = accepted_q;
  assign m_axis_tdata  = {{(dtts_pkg::M_TDATA_W - dtts_pkg::TOTAL_W - dtts_pkg::FRAC_W){1'b0}},
                          frac_out_q, seconds_q};

  // A stalled input side always has a character waiting in the parse stage.
  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_valid_q)
    else $error("input stalled with an empty parse stage");

  // The last character of a string returns the parser to the start.
  a_restart_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (phase_q == dtts_pkg::PH_WANT_P && total_q == '0 && !any_q))
    else $error("parser not restarted after a result");

  // A rejected string reports zero seconds and zero fraction.
  a_reject_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !accepted_q) |-> (seconds_q == '0 && frac_out_q == '0))
    else $error("rejected result carries a value");

  // The digit counts never pass their limits.
  a_count_limits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (num_cnt_q <= NUM_MAX) && (frac_cnt_q <= FRAC_MAX))
    else $error("digit count beyond its limit");

endmodule

`default_nettype wire

@@ sim/tb_duration_text_to_seconds.sv @@
// Testbench for the duration text parser: directed strings, random strings, checked per result.

module tb_duration_text_to_seconds;

  // Characters the parser gives meaning to.
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_T      = 8'h54;
  localparam logic [7:0] CH_Y      = 8'h59;
  localparam logic [7:0] CH_W      = 8'h57;
  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_H      = 8'h48;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CASE_BIT  = 8'h20;
  localparam logic [7:0] UPPER_MASK = 8'hDF;

  // Seconds per unit and the ceiling of the running sum.
  localparam longint unsigned SUM_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam longint unsigned SECS_YEAR    = 31536000;
  localparam longint unsigned SECS_MONTH   = 2592000;
  localparam longint unsigned SECS_WEEK    = 604800;
  localparam longint unsigned SECS_DAY     = 86400;
  localparam longint unsigned SECS_HOUR    = 3600;
  localparam longint unsigned SECS_MINUTE  = 60;
  localparam int unsigned NUM_DIGITS_MAX  = dtts_pkg::DEF_MAX_NUMBER_DIGITS;
  localparam int unsigned FRAC_DIGITS_MAX = dtts_pkg::DEF_MAX_FRACTION_DIGITS;

  localparam int unsigned RANDOM_CHARS = 900;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef struct packed {
    logic                          accepted;
    logic [dtts_pkg::TOTAL_W-1:0]  seconds;
    logic [dtts_pkg::FRAC_W-1:0]   fraction;
  } duration_t;

  typedef struct {
    string     text;
    bit        typed;
    duration_t want;
  } text_case_t;

  logic                           clk_i;
  logic                           rst_ni = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [dtts_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;    // char_code[7:0]
  logic                           s_axis_tlast = 1'b0;  // last
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [dtts_pkg::M_TDATA_W-1:0] m_axis_tdata;  // seconds[62:0], fraction_value[72:63]
  logic                           m_axis_tuser;  // accepted

  duration_t   durations_due[$];
  text_case_t  directed_rows[$];
  logic [7:0]  text_bytes[$];
  duration_t   due_head;

  int unsigned error_count;
  int unsigned results_seen;
  int unsigned chars_sent;
  int unsigned strings_sent;
  int unsigned accepts_due;
  int unsigned stall_left;
  int unsigned ready_roll;
  int unsigned cycle_count;
  bit          steady_mode;

  // Parser state as the predictor tracks it.
  dtts_pkg::phase_e pr_phase;
  longint unsigned  pr_number;
  int unsigned      pr_ndigits;
  int unsigned      pr_frac;
  int unsigned      pr_fdigits;
  longint unsigned  pr_total;
  bit               pr_time_part;
  bit               pr_week_seen;
  bit               pr_year_ctx;
  bit               pr_any_unit;

  duration_text_to_seconds uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #20000000;
    $display("tb_duration_text_to_seconds: done, errors");
    $finish;
  end

  function automatic bit is_digit(logic [7:0] ch);
    return ch >= CH_ZERO && ch <= CH_NINE;
  endfunction

  function automatic bit is_space(logic [7:0] ch);
    return ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR);
  endfunction

  function automatic void clear_parse();
    pr_phase     = dtts_pkg::PH_WANT_P;
    pr_number    = 0;
    pr_ndigits   = 0;
    pr_frac      = 0;
    pr_fdigits   = 0;
    pr_total     = 0;
    pr_time_part = 1'b0;
    pr_week_seen = 1'b0;
    pr_year_ctx  = 1'b0;
    pr_any_unit  = 1'b0;
  endfunction

  // Adds the pending number times a unit, refusing any sum past the ceiling.
  function automatic bit add_seconds(longint unsigned scale);
    longint unsigned room;
    room = SUM_MAX - pr_total;
    if (pr_number > room / scale) return 1'b0;
    pr_total = pr_total + pr_number * scale;
    return 1'b1;
  endfunction

  function automatic dtts_pkg::phase_e take_unit_letter(logic [7:0] ch);
    bit ok;
    ok = 1'b1;
    case (ch & UPPER_MASK)
      CH_Y: begin
        if (pr_time_part) return dtts_pkg::PH_REJECT;
        pr_year_ctx = 1'b1;
        ok = add_seconds(SECS_YEAR);
      end
      CH_W: begin
        if (pr_time_part) return dtts_pkg::PH_REJECT;
        pr_week_seen = 1'b1;
        pr_year_ctx = 1'b0;
        ok = add_seconds(SECS_WEEK);
      end
      CH_D: begin
        if (pr_time_part) return dtts_pkg::PH_REJECT;
        pr_year_ctx = 1'b0;
        ok = add_seconds(SECS_DAY);
      end
      CH_H: begin
        pr_year_ctx = 1'b0;
        ok = add_seconds(SECS_HOUR);
      end
      CH_M: begin
        ok = add_seconds(pr_year_ctx ? SECS_MONTH : SECS_MINUTE);
      end
      CH_S: begin
        pr_year_ctx = 1'b0;
        ok = add_seconds(64'd1);
      end
      CH_T: begin
        // The number in front of a T is dropped.
        if (pr_week_seen) return dtts_pkg::PH_REJECT;
        pr_year_ctx = 1'b0;
        pr_time_part = 1'b1;
      end
      default: return dtts_pkg::PH_REJECT;
    endcase
    if (!ok) return dtts_pkg::PH_REJECT;
    pr_any_unit = 1'b1;
    return dtts_pkg::PH_NUM_START;
  endfunction

  function automatic dtts_pkg::phase_e after_number(logic [7:0] ch);
    if (is_space(ch)) return dtts_pkg::PH_NUM_WS;
    if (ch == CH_DOT) begin
      if (pr_week_seen) return dtts_pkg::PH_REJECT;
      pr_frac = 0;
      pr_fdigits = 0;
      return dtts_pkg::PH_FRAC_START;
    end
    return take_unit_letter(ch);
  endfunction

  // A fractional S adds the whole seconds once and keeps the year context.
  function automatic dtts_pkg::phase_e close_fraction();
    if (!add_seconds(64'd1)) return dtts_pkg::PH_REJECT;
    pr_any_unit = 1'b1;
    return dtts_pkg::PH_NUM_START;
  endfunction

  function automatic dtts_pkg::phase_e next_parse_phase(logic [7:0] ch);
    case (pr_phase)
      dtts_pkg::PH_WANT_P:
        return (ch == CH_P) ? dtts_pkg::PH_AFTER_P : dtts_pkg::PH_REJECT;
      dtts_pkg::PH_AFTER_P, dtts_pkg::PH_NUM_START: begin
        if (pr_phase == dtts_pkg::PH_AFTER_P && (ch & UPPER_MASK) == CH_T) begin
          pr_time_part = 1'b1;
          return dtts_pkg::PH_NUM_START;
        end
        // A byte that cannot open a group ends parsing here.
        if (!is_digit(ch)) return pr_any_unit ? dtts_pkg::PH_ACCEPT : dtts_pkg::PH_REJECT;
        pr_number = 64'(ch - CH_ZERO);
        pr_ndigits = 1;
        return dtts_pkg::PH_NUM;
      end
      dtts_pkg::PH_NUM: begin
        if (is_digit(ch)) begin
          if (pr_ndigits >= NUM_DIGITS_MAX) return dtts_pkg::PH_REJECT;
          pr_number = pr_number * 10 + 64'(ch - CH_ZERO);
          pr_ndigits++;
          return dtts_pkg::PH_NUM;
        end
        return after_number(ch);
      end
      dtts_pkg::PH_NUM_WS: return after_number(ch);
      dtts_pkg::PH_FRAC_START: begin
        if (!is_digit(ch)) return dtts_pkg::PH_REJECT;
        pr_frac = 32'(ch - CH_ZERO);
        pr_fdigits = 1;
        return dtts_pkg::PH_FRAC;
      end
      dtts_pkg::PH_FRAC: begin
        if (is_digit(ch)) begin
          if (pr_fdigits >= FRAC_DIGITS_MAX) return dtts_pkg::PH_REJECT;
          pr_frac = pr_frac * 10 + 32'(ch - CH_ZERO);
          pr_fdigits++;
          return dtts_pkg::PH_FRAC;
        end
        if (is_space(ch)) return dtts_pkg::PH_FRAC_WS;
        if ((ch & UPPER_MASK) == CH_S) return close_fraction();
        return dtts_pkg::PH_REJECT;
      end
      dtts_pkg::PH_FRAC_WS: begin
        if (is_space(ch)) return dtts_pkg::PH_FRAC_WS;
        if ((ch & UPPER_MASK) == CH_S) return close_fraction();
        return dtts_pkg::PH_REJECT;
      end
      dtts_pkg::PH_ACCEPT: return dtts_pkg::PH_ACCEPT;
      default: return dtts_pkg::PH_REJECT;
    endcase
  endfunction

  // Advances the predictor by one character; returns 1 when a result is due.
  function automatic bit settle_char(input logic [7:0] ch, input bit fin,
                                     output duration_t res);
    bit ok;
    pr_phase = next_parse_phase(ch);
    res = '0;
    if (!fin) return 1'b0;
    case (pr_phase)
      dtts_pkg::PH_ACCEPT: ok = 1'b1;
      dtts_pkg::PH_AFTER_P, dtts_pkg::PH_NUM_START,
      dtts_pkg::PH_NUM, dtts_pkg::PH_NUM_WS: ok = pr_any_unit;
      default: ok = 1'b0;
    endcase
    res.accepted = ok;
    res.seconds  = ok ? pr_total[dtts_pkg::TOTAL_W-1:0] : '0;
    res.fraction = ok ? pr_frac[dtts_pkg::FRAC_W-1:0] : '0;
    clear_parse();
    return 1'b1;
  endfunction

  function automatic void add_row(string text, bit typed, bit acc,
                                  logic [dtts_pkg::TOTAL_W-1:0] secs,
                                  logic [dtts_pkg::FRAC_W-1:0] frac);
    text_case_t row;
    row.text = text;
    row.typed = typed;
    row.want.accepted = acc;
    row.want.seconds = secs;
    row.want.fraction = frac;
    directed_rows.push_back(row);
  endfunction

  // Idle time before a character: mostly none, sometimes short, rarely long.
  function automatic int unsigned idle_cycles();
    int unsigned roll;
    if (steady_mode) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] with_case(logic [7:0] ch);
    return $urandom_range(0, 1) ? (ch | CASE_BIT) : ch;
  endfunction

  function automatic logic [7:0] random_space();
    int unsigned pick;
    pick = $urandom_range(0, 5);
    return (pick == 5) ? CH_SPACE : CH_TAB + 8'(pick);
  endfunction

  function automatic void push_digits(int unsigned count);
    repeat (count) text_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
  endfunction

  // Mostly well formed durations with random content, some noise and broken ones.
  function automatic void build_random_text();
    int unsigned roll;
    int unsigned ndig;
    logic [7:0]  unit;
    text_bytes.delete();
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      repeat ($urandom_range(1, 8)) text_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if (roll < 11) text_bytes.push_back(8'($urandom_range(0, 255)));
    else text_bytes.push_back(CH_P);
    if ($urandom_range(0, 3) == 0) text_bytes.push_back(with_case(CH_T));
    repeat ($urandom_range(1, 4)) begin
      roll = $urandom_range(0, 99);
      if (roll < 55) ndig = $urandom_range(1, 2);
      else if (roll < 82) ndig = $urandom_range(3, 5);
      else if (roll < 97) ndig = $urandom_range(6, NUM_DIGITS_MAX);
      else ndig = NUM_DIGITS_MAX + 1;
      push_digits(ndig);
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 2)) text_bytes.push_back(random_space());
      roll = $urandom_range(0, 99);
      if (roll < 78) begin
        case ($urandom_range(0, 6))
          0: unit = CH_Y;
          1: unit = CH_W;
          2: unit = CH_D;
          3: unit = CH_H;
          4: unit = CH_M;
          5: unit = CH_S;
          default: unit = CH_T;
        endcase
        text_bytes.push_back(with_case(unit));
      end else if (roll < 93) begin
        text_bytes.push_back(CH_DOT);
        push_digits(($urandom_range(0, 19) == 0) ? FRAC_DIGITS_MAX + 1
                                                  : $urandom_range(1, FRAC_DIGITS_MAX));
        if ($urandom_range(0, 4) == 0) text_bytes.push_back(random_space());
        roll = $urandom_range(0, 99);
        if (roll < 84) text_bytes.push_back(with_case(CH_S));
        else if (roll < 92) text_bytes.push_back(with_case(CH_M));
      end else begin
        text_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
    // Optional tail: a dangling number or a stray byte.
    roll = $urandom_range(0, 99);
    if (roll < 12) push_digits($urandom_range(1, 3));
    else if (roll < 18) text_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("MISMATCH result %0d: %s got 0x%0h, expected 0x%0h",
             results_seen, what, got, want);
    error_count++;
  endtask

  // Offers one character and waits for it to be taken, then updates the prediction.
  task automatic deliver_char(input logic [7:0] ch, input bit fin,
                              input bit has_typed, input duration_t typed);
    int unsigned gap;
    duration_t   res;
    gap = idle_cycles();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= fin;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    chars_sent++;
    if (settle_char(ch, fin, res)) begin
      if (has_typed) res = typed;
      durations_due.push_back(res);
      strings_sent++;
      if (res.accepted) accepts_due++;
    end
  endtask

  // Calm stretches with no idling on either side.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 300 == 0) steady_mode <= ($urandom_range(0, 3) == 0);
  end

  // Result side back-pressure.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (steady_mode) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 70) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        stall_left = (ready_roll < 96) ? $urandom_range(0, 2) : $urandom_range(8, 40);
      end
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (durations_due.size() == 0) begin
        report_mismatch("result with nothing expected",
                        m_axis_tdata[dtts_pkg::TOTAL_W-1:0], 0);
      end else begin
        due_head = durations_due.pop_front();
        if (m_axis_tuser !== due_head.accepted)
          report_mismatch("accepted", m_axis_tuser, due_head.accepted);
        if (m_axis_tdata[dtts_pkg::TOTAL_W-1:0] !== due_head.seconds)
          report_mismatch("seconds", m_axis_tdata[dtts_pkg::TOTAL_W-1:0],
                          due_head.seconds);
        if (m_axis_tdata[dtts_pkg::TOTAL_W+dtts_pkg::FRAC_W-1:dtts_pkg::TOTAL_W]
            !== due_head.fraction)
          report_mismatch("fraction_value",
                          m_axis_tdata[dtts_pkg::TOTAL_W+dtts_pkg::FRAC_W-1:dtts_pkg::TOTAL_W],
                          due_head.fraction);
      end
    end
  end

  initial begin
    int unsigned random_start;
    int unsigned len;
    duration_t   none;
    none = '0;
    clear_parse();

    // Directed strings; the typed rows carry their expected result, the others use the predictor.
    add_row("P1Y",            1'b1, 1'b1, 63'd31536000, 10'd0);
    add_row("PT1M",           1'b1, 1'b1, 63'd60, 10'd0);
    add_row("P1W",            1'b1, 1'b1, 63'd604800, 10'd0);
    add_row("p1D",            1'b1, 1'b0, 63'd0, 10'd0);
    add_row("P",              1'b1, 1'b0, 63'd0, 10'd0);
    add_row("PT",             1'b1, 1'b0, 63'd0, 10'd0);
    add_row("P 1Y",           1'b1, 1'b0, 63'd0, 10'd0);
    add_row("P1X",            1'b1, 1'b0, 63'd0, 10'd0);
    add_row("P123456789012S", 1'b1, 1'b1, 63'd123456789012, 10'd0);
    add_row("P1234567890123S", 1'b1, 1'b0, 63'd0, 10'd0);
    add_row("PT1.5S",         1'b1, 1'b1, 63'd1, 10'd5);
    add_row("PT2.1234S",      1'b1, 1'b0, 63'd0, 10'd0);
    add_row("P1.5",           1'b1, 1'b0, 63'd0, 10'd0);
    add_row("PT1D",           1'b1, 1'b0, 63'd0, 10'd0);
    add_row("P1W2T3H",        1'b1, 1'b0, 63'd0, 10'd0);
    add_row("P1W1.5S",        1'b1, 1'b0, 63'd0, 10'd0);
    add_row("P999999999999Y", 1'b1, 1'b0, 63'd0, 10'd0);
    add_row("P292471208677Y16903807S", 1'b1, 1'b1, 63'h7FFF_FFFF_FFFF_FFFF, 10'd0);
    add_row("P292471208677Y16903808S", 1'b1, 1'b0, 63'd0, 10'd0);
    add_row("P1Y2M",          1'b0, 1'b0, 63'd0, 10'd0);
    add_row("P1d2h3m4s",      1'b0, 1'b0, 63'd0, 10'd0);
    add_row("P1Y\3779Z",      1'b0, 1'b0, 63'd0, 10'd0);
    add_row("P5H 7",          1'b0, 1'b0, 63'd0, 10'd0);
    add_row("P2\t \r\nD",     1'b0, 1'b0, 63'd0, 10'd0);
    add_row("PT3.25 s",       1'b0, 1'b0, 63'd0, 10'd0);
    add_row("P1Y2.5S3M",      1'b0, 1'b0, 63'd0, 10'd0);
    add_row("P1YT2M",         1'b0, 1'b0, 63'd0, 10'd0);
    add_row("P1H1T5S",        1'b0, 1'b0, 63'd0, 10'd0);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      len = directed_rows[r].text.len();
      for (int unsigned i = 0; i < len; i++)
        deliver_char(directed_rows[r].text[i], i == len - 1,
                     directed_rows[r].typed, directed_rows[r].want);
    end

    // Random strings until enough characters have gone in.
    random_start = chars_sent;
    while (chars_sent - random_start < RANDOM_CHARS) begin
      build_random_text();
      foreach (text_bytes[i])
        deliver_char(text_bytes[i], i == text_bytes.size() - 1, 1'b0, none);
    end
    s_axis_tvalid <= 1'b0;

    while (durations_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Parsed %0d strings from %0d characters; %0d results checked, %0d accepted.",
             strings_sent, chars_sent, results_seen, accepts_due);
    if (error_count == 0)
      $display("tb_duration_text_to_seconds: done, clean");
    else
      $display("tb_duration_text_to_seconds: done, errors");
    $finish;
  end

endmodule
